>>> rtl/salc_pkg.sv
// Package for the set-associative LRU cache model: types and constants.
// No dependencies.
`default_nettype none
package salc_pkg;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 32;

  typedef enum logic [1:0] {
    ACT_INSTR  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_STORE  = 2'd2,
    ACT_MODIFY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_WRITE = 2'd2
  } bk_state_t;
endpackage
`default_nettype wire

>>> rtl/salc_if.sv
// Valid/ready stream interfaces for the cache model's input and result channels.
// Depends on nothing.
`default_nettype none
interface salc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;
  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

interface salc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  hits_now;
  logic        misses_now;
  logic        evicted_now;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;
  modport source (output valid, hits_now, misses_now, evicted_now, hit_total, miss_total,
                  eviction_total, input ready);
  modport sink   (input valid, hits_now, misses_now, evicted_now, hit_total, miss_total,
                  eviction_total, output ready);
endinterface
`default_nettype wire

>>> rtl/set_assoc_lru_cache_sim.sv
// Set-associative cache model with LRU replacement, two-entry queue between front and back.
// The back end takes one item at a time through its read, compare and write steps and
// accepts the next only when the result register is empty or being taken.
// Reset (rst_n low, synchronous) clears counters, queue and control registers; then a pass
// over all 2**MAX_SET_BITS sets (256 by default) zeroes valid rows before the first lookup.
`default_nettype none
module set_assoc_lru_cache_sim import salc_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = 8,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_wdata,
  salc_in_if.sink         in_ch,
  salc_out_if.source      out_ch
);
  logic [3:0] set_bits_r, ways_r;
  logic [4:0] block_bits_r;

  logic                    q_valid, q_pop;
  logic [1:0]              q_action;
  logic [MAX_SET_BITS-1:0] q_set;
  logic [31:0]             q_tag;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= 4'd4; ways_r <= 4'd1; block_bits_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[3:0];
        CFG_WAYS:       ways_r       <= cfg_wdata[3:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The front end splits addresses with the configuration at transfer time.
  salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
    .clk, .rst_n,
    .set_bits(set_bits_r), .block_bits(block_bits_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(in_ch.action), .in_address(in_ch.address),
    .q_valid, .q_pop, .q_action, .q_set, .q_tag
  );

  // The back end does the lookup and owns the result register.
  salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk, .rst_n, .ways_in_use(ways_r),
    .q_valid, .q_pop, .q_action, .q_set, .q_tag,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_hits_now(out_ch.hits_now), .out_misses_now(out_ch.misses_now),
    .out_evicted_now(out_ch.evicted_now), .out_hit_total(out_ch.hit_total),
    .out_miss_total(out_ch.miss_total), .out_eviction_total(out_ch.eviction_total)
  );
endmodule
`default_nettype wire

>>> rtl/salc_front.sv
// Front end: accepts items, splits the address into set and tag, and queues them.
// Depends on salc_pkg.
`default_nettype none
module salc_front import salc_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [3:0]              set_bits,
  input  wire logic [4:0]              block_bits,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_action,
  input  wire logic [31:0]             in_address,
  output logic                         q_valid,
  input  wire logic                    q_pop,
  output logic [1:0]                   q_action,
  output logic [MAX_SET_BITS-1:0]      q_set,
  output logic [31:0]                  q_tag
);
  localparam int unsigned ENT_W = 2 + MAX_SET_BITS + 32;
  logic [ENT_W-1:0] q_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic [4:0]       s_c, b_c;
  logic [31:0]      shifted;
  logic [31:0]      set_mask;
  logic [MAX_SET_BITS-1:0] set_v;
  logic [31:0]      tag_v;
  logic             push;

  // Clamp the configuration to its legal ranges.
  always_comb begin
    if (set_bits == 4'd0) s_c = 5'd1;
    else if (32'(set_bits) > MAX_SET_BITS) s_c = 5'(MAX_SET_BITS);
    else s_c = {1'b0, set_bits};
    if (block_bits == 5'd0) b_c = 5'd1;
    else if (block_bits > 5'd16) b_c = 5'd16;
    else b_c = block_bits;
    shifted  = in_address >> b_c;
    set_mask = (32'd1 << s_c) - 32'd1;
    set_v    = MAX_SET_BITS'(shifted & set_mask);
    tag_v    = shifted >> s_c;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign {q_action, q_set, q_tag} = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= {in_action, set_v, tag_v};
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/salc_back.sv
// Back end: reads one set, compares ways in use, picks hit/fill/victim, writes
// back, updates totals and holds the result register. Depends on salc_pkg.
`default_nettype none
module salc_back import salc_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = 8,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [3:0]           ways_in_use,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire logic [1:0]           q_action,
  input  wire logic [MAX_SET_BITS-1:0] q_set,
  input  wire logic [31:0]          q_tag,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_hits_now,
  output logic                      out_misses_now,
  output logic                      out_evicted_now,
  output logic [31:0]               out_hit_total,
  output logic [31:0]               out_miss_total,
  output logic [31:0]               out_eviction_total
);
  localparam int unsigned SETS = 1 << MAX_SET_BITS;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  bk_state_t st_r, st_nxt;

  // One row per set holds all ways. The valid rows are zeroed by a clearing
  // pass over every set after reset; no lookup starts before it ends.
  logic [MAX_WAYS-1:0]    valid_mem [SETS];
  logic [MAX_WAYS*32-1:0] tag_mem [SETS];
  logic [MAX_WAYS*32-1:0] use_mem [SETS];
  logic [MAX_WAYS*32-1:0] tag_rd_r, use_rd_r;
  logic [MAX_WAYS-1:0]    vld_rd_r;
  logic                    clr_busy_r;
  logic [MAX_SET_BITS-1:0] clr_idx_r;

  logic [1:0]              act_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [31:0]             tag_r;
  logic [31:0]             clk_cnt_r;
  logic [31:0]             hit_tot_r, miss_tot_r, ev_tot_r;
  logic                    ovalid_r;
  logic [1:0]              hn_r;
  logic                    mn_r, en_r;

  logic [4:0]        e_c;
  logic              hit;
  logic              has_free;
  logic [WAY_W-1:0]  hit_w, free_w, vic_w, sel_w;
  logic [31:0]       best_age, age;
  logic              accept, do_write;
  logic [1:0]        hits_v;
  logic [31:0]       ht1, ht2;

  always_comb begin
    if (ways_in_use == 4'd0) e_c = 5'd1;
    else if (32'(ways_in_use) > MAX_WAYS) e_c = 5'(MAX_WAYS);
    else e_c = {1'b0, ways_in_use};
  end

  // Parallel compare of the ways in use in the registered row.
  always_comb begin
    hit = 1'b0; hit_w = '0; has_free = 1'b0; free_w = '0;
    vic_w = '0; best_age = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(e_c)) begin
        if (vld_rd_r[w] && tag_rd_r[w*32 +: 32] == tag_r) begin
          hit = 1'b1; hit_w = WAY_W'(w);
        end
        if (!vld_rd_r[w]) begin
          has_free = 1'b1; free_w = WAY_W'(w);
        end
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      age = clk_cnt_r - use_rd_r[w*32 +: 32];
      if (w < int'(e_c) && (w == 0 || age > best_age)) begin
        best_age = age; vic_w = WAY_W'(w);
      end
    end
    sel_w = hit ? hit_w : (has_free ? free_w : vic_w);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (!clr_busy_r && q_valid && (!ovalid_r || out_ready)) st_nxt = BK_READ;
      BK_READ:  st_nxt = BK_WRITE;
      BK_WRITE: st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    accept   = (st_r == BK_IDLE) && !clr_busy_r && q_valid && (!ovalid_r || out_ready);
    q_pop    = accept;
    do_write = (st_r == BK_WRITE) && (act_r != ACT_INSTR);
  end

  always_comb begin
    hits_v = 2'd0;
    if (act_r != ACT_INSTR) hits_v = 2'(hit) + 2'(act_r == ACT_MODIFY);
    ht1 = (hits_v != 2'd0 && hit_tot_r != '1) ? hit_tot_r + 32'd1 : hit_tot_r;
    ht2 = (hits_v == 2'd2 && ht1 != '1) ? ht1 + 32'd1 : ht1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= q_action; set_r <= q_set; tag_r <= q_tag;
    end
    if (st_r == BK_READ) begin
      tag_rd_r <= tag_mem[set_r];
      use_rd_r <= use_mem[set_r];
    end
    if (do_write) begin
      tag_mem[set_r][sel_w*32 +: 32] <= tag_r;
      use_mem[set_r][sel_w*32 +: 32] <= clk_cnt_r;
    end
    if (clr_busy_r) valid_mem[clr_idx_r] <= '0;
    else if (do_write) valid_mem[set_r] <= vld_rd_r | (MAX_WAYS'(1) << sel_w);
    if (st_r == BK_WRITE) begin
      hn_r <= hits_v;
      mn_r <= (act_r != ACT_INSTR) && !hit;
      en_r <= (act_r != ACT_INSTR) && !hit && !has_free;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ovalid_r <= 1'b0;
      clk_cnt_r <= '0; hit_tot_r <= '0; miss_tot_r <= '0; ev_tot_r <= '0;
      vld_rd_r <= '0;
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + MAX_SET_BITS'(1);
        if (clr_idx_r == '1) clr_busy_r <= 1'b0;
      end
      if (st_r == BK_READ) vld_rd_r <= valid_mem[set_r];
      if (st_r == BK_WRITE) begin
        clk_cnt_r <= clk_cnt_r + 32'd1;
        hit_tot_r <= ht2;
        if (act_r != ACT_INSTR && !hit && miss_tot_r != '1) miss_tot_r <= miss_tot_r + 32'd1;
        if (act_r != ACT_INSTR && !hit && !has_free && ev_tot_r != '1)
          ev_tot_r <= ev_tot_r + 32'd1;
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = ovalid_r;
  assign out_hits_now       = hn_r;
  assign out_misses_now     = mn_r;
  assign out_evicted_now    = en_r;
  assign out_hit_total      = hit_tot_r;
  assign out_miss_total     = miss_tot_r;
  assign out_eviction_total = ev_tot_r;
endmodule
`default_nettype wire

>>> rtl/salc_checker.sv
// Port-level checker for the cache model, bound to the top level.
// Depends on salc_pkg.
`default_nettype none
module salc_checker import salc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_hits_now,
  input wire logic        out_misses_now,
  input wire logic        out_evicted_now,
  input wire logic [31:0] out_miss_total
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_now |-> out_misses_now) else $error("eviction without miss");
  a_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hits_now != 2'd3) else $error("bad hit count");
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid |-> out_miss_total >= $past(out_miss_total))
    else $error("miss total went down");
endmodule

bind set_assoc_lru_cache_sim salc_checker u_chk (
  .clk, .rst_n,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_hits_now(out_ch.hits_now), .out_misses_now(out_ch.misses_now),
  .out_evicted_now(out_ch.evicted_now), .out_miss_total(out_ch.miss_total)
);
`default_nettype wire
